### sv/mjq_pkg.sv
// mjq_pkg: widths, constants and shared types for the quintic coefficient solver
// used by every module of the block; depends on nothing

package mjq_pkg;

    localparam int DATA_W     = 32;
    localparam int DUR_W      = 24;
    localparam int IN_W       = 6 * DATA_W + DUR_W;
    localparam int OUT_W      = 6 * DATA_W;
    localparam int X_W        = 84;
    localparam int M_W        = 88;
    localparam int MAG_W      = 136;
    localparam int DEN_W      = 120;
    localparam int REM_W      = DEN_W + 1;
    localparam int QUO_W      = 32;
    localparam int DIV_STEPS  = QUO_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int SH3        = 15;
    localparam int SH4        = 31;
    localparam int SH5        = 47;

    localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] coef0;
        logic [DATA_W-1:0] coef1;
        logic [DATA_W-1:0] coef2;
        logic              nz;
    } side_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } div_in_t;

    typedef struct packed {
        side_t         side;
        div_in_t [2:0] div;
    } job_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [QUO_W-1:0] low;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             ovf;
    } div_stage_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } div_out_t;

endpackage

### sv/mjq_front.sv
// mjq_front: accepts input words and builds the three signed numerators and
// the powers of the duration in a five stage pipeline; uses mjq_pkg

module mjq_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [mjq_pkg::IN_W-1:0]  s_tdata,
    input  logic                      fifo_full,
    output logic                      push,
    output mjq_pkg::job_t             job
);

    logic fe;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // input fields
    logic signed [mjq_pkg::DATA_W-1:0] in_p0, in_v0, in_s0, in_p1, in_v1, in_s1;
    logic [mjq_pkg::DUR_W-1:0]         in_d;
    logic signed [mjq_pkg::DUR_W:0]    in_ds;
    logic signed [mjq_pkg::DATA_W:0]   s0_w, half_w;

    // stage 1
    logic signed [32:0] dp1_reg, ds1_reg;
    logic signed [56:0] vd1_reg, sd1_reg;
    logic signed [48:0] dv1_reg;
    logic [47:0]        dd1_reg;
    logic [mjq_pkg::DUR_W-1:0]  d1_reg;
    logic [mjq_pkg::DATA_W-1:0] p0_1_reg, v0_1_reg, half1_reg;
    logic signed [mjq_pkg::DUR_W:0] d1_s;

    // stage 2
    logic signed [81:0]            t2_reg;
    logic signed [57:0]            a2_reg, dsd2_reg;
    logic signed [mjq_pkg::X_W-1:0] x0p2_reg;
    logic [71:0]                   d3_2_reg;
    logic [mjq_pkg::DUR_W-1:0]     d2_reg;
    logic [mjq_pkg::DATA_W-1:0]    p0_2_reg, v0_2_reg, half2_reg;
    logic signed [mjq_pkg::DUR_W:0] d2_s;
    logic signed [mjq_pkg::X_W-1:0] dp_x, vd_x;

    // stage 3
    logic signed [mjq_pkg::X_W-1:0] x0_3_reg, x1_3_reg, x2_3_reg;
    logic [95:0]                   d4_3_reg;
    logic [71:0]                   d3_3_reg;
    logic [mjq_pkg::DUR_W-1:0]     d3r_reg;
    logic [mjq_pkg::DATA_W-1:0]    p0_3_reg, v0_3_reg, half3_reg;

    // stage 4
    logic signed [mjq_pkg::M_W-1:0] m3_4_reg, m4_4_reg, m5_4_reg;
    logic [mjq_pkg::DEN_W-1:0]     d5_4_reg;
    logic [95:0]                   d4_4_reg;
    logic [71:0]                   d3_4_reg;
    logic                          nz4_reg;
    logic [mjq_pkg::DATA_W-1:0]    p0_4_reg, v0_4_reg, half4_reg;
    logic signed [mjq_pkg::M_W-1:0] ex0, ex1, ex2, m3_w, m4_w, m5_w;

    // stage 5
    mjq_pkg::job_t job_reg, job_next;
    logic [mjq_pkg::M_W-1:0] abs3, abs4, abs5;

    assign fe       = !v5_reg || !fifo_full;
    assign s_tready = fe;
    assign push     = v5_reg && !fifo_full;
    assign job      = job_reg;

    assign in_p0 = s_tdata[0*mjq_pkg::DATA_W +: mjq_pkg::DATA_W];
    assign in_v0 = s_tdata[1*mjq_pkg::DATA_W +: mjq_pkg::DATA_W];
    assign in_s0 = s_tdata[2*mjq_pkg::DATA_W +: mjq_pkg::DATA_W];
    assign in_p1 = s_tdata[3*mjq_pkg::DATA_W +: mjq_pkg::DATA_W];
    assign in_v1 = s_tdata[4*mjq_pkg::DATA_W +: mjq_pkg::DATA_W];
    assign in_s1 = s_tdata[5*mjq_pkg::DATA_W +: mjq_pkg::DATA_W];
    assign in_d  = s_tdata[6*mjq_pkg::DATA_W +: mjq_pkg::DUR_W];
    assign in_ds = {1'b0, in_d};
    assign d1_s  = {1'b0, d1_reg};
    assign d2_s  = {1'b0, d2_reg};

    // half of the start acceleration, ties away from zero
    always_comb begin
        s0_w = in_s0;
        if (in_s0 >= 0) begin
            half_w = (s0_w + 33'sd1) >>> 1;
        end else begin
            half_w = -((33'sd1 - s0_w) >>> 1);
        end
    end

    always_comb begin
        dp_x = dp1_reg;
        vd_x = vd1_reg;
        dp_x = dp_x <<< 33;
        vd_x = vd_x <<< 17;
    end

    // numerators of the three high coefficients
    always_comb begin
        ex0  = x0_3_reg;
        ex1  = x1_3_reg;
        ex2  = x2_3_reg;
        m3_w = (ex0 <<< 3) + (ex0 <<< 1) - (ex1 <<< 3) + ex2;
        m4_w = (ex1 <<< 4) - (ex1 <<< 1) - ((ex0 <<< 4) - ex0) - (ex2 <<< 1);
        m5_w = (ex0 <<< 2) + (ex0 <<< 1) - (ex1 <<< 2) - (ex1 <<< 1) + ex2;
    end

    always_comb begin
        abs3 = m3_4_reg[mjq_pkg::M_W-1] ? -m3_4_reg : m3_4_reg;
        abs4 = m4_4_reg[mjq_pkg::M_W-1] ? -m4_4_reg : m4_4_reg;
        abs5 = m5_4_reg[mjq_pkg::M_W-1] ? -m5_4_reg : m5_4_reg;
        job_next.side.coef0 = p0_4_reg;
        job_next.side.coef1 = v0_4_reg;
        job_next.side.coef2 = half4_reg;
        job_next.side.nz    = nz4_reg;
        job_next.div[0].neg = m3_4_reg[mjq_pkg::M_W-1];
        job_next.div[1].neg = m4_4_reg[mjq_pkg::M_W-1];
        job_next.div[2].neg = m5_4_reg[mjq_pkg::M_W-1];
        job_next.div[0].mag = mjq_pkg::MAG_W'(abs3) << mjq_pkg::SH3;
        job_next.div[1].mag = mjq_pkg::MAG_W'(abs4) << mjq_pkg::SH4;
        job_next.div[2].mag = mjq_pkg::MAG_W'(abs5) << mjq_pkg::SH5;
        job_next.div[0].den = mjq_pkg::DEN_W'(d3_4_reg);
        job_next.div[1].den = mjq_pkg::DEN_W'(d4_4_reg);
        job_next.div[2].den = d5_4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (fe) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fe) begin
            dp1_reg   <= in_p1 - in_p0;
            ds1_reg   <= in_s1 - in_s0;
            vd1_reg   <= in_v0 * in_ds;
            sd1_reg   <= in_s0 * in_ds;
            dv1_reg   <= (in_v1 - in_v0) <<< 16;
            dd1_reg   <= in_d * in_d;
            d1_reg    <= in_d;
            p0_1_reg  <= in_p0;
            v0_1_reg  <= in_v0;
            half1_reg <= half_w[mjq_pkg::DATA_W-1:0];

            t2_reg    <= sd1_reg * d1_s;
            a2_reg    <= dv1_reg - sd1_reg;
            x0p2_reg  <= dp_x - vd_x;
            dsd2_reg  <= ds1_reg * d1_s;
            d3_2_reg  <= dd1_reg * d1_reg;
            d2_reg    <= d1_reg;
            p0_2_reg  <= p0_1_reg;
            v0_2_reg  <= v0_1_reg;
            half2_reg <= half1_reg;

            x0_3_reg  <= x0p2_reg - t2_reg;
            x1_3_reg  <= a2_reg * d2_s;
            x2_3_reg  <= dsd2_reg * d2_s;
            d4_3_reg  <= d3_2_reg * d2_reg;
            d3_3_reg  <= d3_2_reg;
            d3r_reg   <= d2_reg;
            p0_3_reg  <= p0_2_reg;
            v0_3_reg  <= v0_2_reg;
            half3_reg <= half2_reg;

            m3_4_reg  <= m3_w;
            m4_4_reg  <= m4_w;
            m5_4_reg  <= m5_w;
            d5_4_reg  <= d4_3_reg * d3r_reg;
            d4_4_reg  <= d4_3_reg;
            d3_4_reg  <= d3_3_reg;
            nz4_reg   <= (d3r_reg != '0);
            p0_4_reg  <= p0_3_reg;
            v0_4_reg  <= v0_3_reg;
            half4_reg <= half3_reg;

            job_reg   <= job_next;
        end
    end

endmodule

### sv/mjq_fifo.sv
// mjq_fifo: short register queue of solve jobs between front and back
// uses mjq_pkg for the job type

module mjq_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mjq_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output mjq_pkg::job_t dout,
    output logic          empty
);

    mjq_pkg::job_t mem_reg [mjq_pkg::FIFO_DEPTH];
    logic [mjq_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mjq_pkg::FIFO_AW:0]   count_reg;

    assign full  = (count_reg == (mjq_pkg::FIFO_AW+1)'(mjq_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### sv/mjq_div.sv
// mjq_div: pipelined restoring divider, one quotient bit per stage, with
// overflow check, rounding half away from zero and clamping; uses mjq_pkg

module mjq_div (
    input  logic              aclk,
    input  logic              en,
    input  mjq_pkg::div_in_t  din,
    output mjq_pkg::div_out_t dout
);

    mjq_pkg::div_stage_t st_reg  [mjq_pkg::DIV_STEPS+1];
    mjq_pkg::div_stage_t st_next [mjq_pkg::DIV_STEPS+1];
    mjq_pkg::div_stage_t last;
    logic [mjq_pkg::REM_W-1:0] shifted [mjq_pkg::DIV_STEPS+1];
    logic [mjq_pkg::REM_W-1:0] den_ext [mjq_pkg::DIV_STEPS+1];
    logic                      rnd;
    logic [mjq_pkg::QUO_W:0]   q33;
    logic                      sat;

    always_comb begin
        // a quotient of 2^32 or more can only saturate
        st_next[0].ovf = ((mjq_pkg::DEN_W+mjq_pkg::QUO_W)'(din.mag)
                          >= {din.den, {mjq_pkg::QUO_W{1'b0}}});
        st_next[0].rem = mjq_pkg::REM_W'(din.mag >> mjq_pkg::QUO_W);
        st_next[0].low = din.mag[mjq_pkg::QUO_W-1:0];
        st_next[0].quo = '0;
        st_next[0].den = din.den;
        st_next[0].neg = din.neg;
        shifted[0]     = '0;
        den_ext[0]     = '0;
        for (int k = 1; k <= mjq_pkg::DIV_STEPS; k++) begin
            shifted[k] = {st_reg[k-1].rem[mjq_pkg::REM_W-2:0],
                          st_reg[k-1].low[mjq_pkg::QUO_W-1]};
            den_ext[k] = {1'b0, st_reg[k-1].den};
            st_next[k] = st_reg[k-1];
            st_next[k].low = {st_reg[k-1].low[mjq_pkg::QUO_W-2:0], 1'b0};
            if (shifted[k] >= den_ext[k]) begin
                st_next[k].rem = shifted[k] - den_ext[k];
                st_next[k].quo = {st_reg[k-1].quo[mjq_pkg::QUO_W-2:0], 1'b1};
            end else begin
                st_next[k].rem = shifted[k];
                st_next[k].quo = {st_reg[k-1].quo[mjq_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= mjq_pkg::DIV_STEPS; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_comb begin
        last = st_reg[mjq_pkg::DIV_STEPS];
        rnd  = ({last.rem, 1'b0} >= {2'b00, last.den});
        q33  = {1'b0, last.quo} + (mjq_pkg::QUO_W+1)'(rnd);
        if (last.neg) begin
            sat = last.ovf || (q33 > {1'b0, mjq_pkg::NEG_LIMIT});
        end else begin
            sat = last.ovf || (q33 > {1'b0, mjq_pkg::POS_LIMIT});
        end
        dout.sat = sat;
        if (sat) begin
            dout.value = last.neg ? mjq_pkg::NEG_LIMIT : mjq_pkg::POS_LIMIT;
        end else if (last.neg) begin
            dout.value = '0 - q33[mjq_pkg::QUO_W-1:0];
        end else begin
            dout.value = q33[mjq_pkg::QUO_W-1:0];
        end
    end

endmodule

### sv/mjq_back.sv
// mjq_back: takes jobs from the queue, runs the three dividers side by side
// and holds the result word in an output register; uses mjq_pkg and mjq_div

module mjq_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mjq_pkg::job_t             job,
    input  logic                      fifo_empty,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [mjq_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tuser
);

    logic be;
    mjq_pkg::side_t    side_reg [mjq_pkg::DIV_STEPS+1];
    logic              vld_reg  [mjq_pkg::DIV_STEPS+1];
    mjq_pkg::div_out_t dres [3];
    mjq_pkg::side_t    tail;
    logic                      m_valid_reg;
    logic [mjq_pkg::OUT_W-1:0] m_data_reg;
    logic                      m_sat_reg;

    assign be       = !m_valid_reg || m_tready;
    assign pop      = be && !fifo_empty;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;
    assign tail     = side_reg[mjq_pkg::DIV_STEPS];

    for (genvar g = 0; g < 3; g++) begin : g_div
        mjq_div u_div (
            .aclk (aclk),
            .en   (be),
            .din  (job.div[g]),
            .dout (dres[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= mjq_pkg::DIV_STEPS; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (be) begin
            vld_reg[0] <= pop;
            for (int k = 1; k <= mjq_pkg::DIV_STEPS; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_valid_reg <= vld_reg[mjq_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            side_reg[0] <= job.side;
            for (int k = 1; k <= mjq_pkg::DIV_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            // zero duration gives zero high coefficients
            if (tail.nz) begin
                m_data_reg <= {dres[2].value, dres[1].value, dres[0].value,
                               tail.coef2, tail.coef1, tail.coef0};
                m_sat_reg  <= dres[0].sat || dres[1].sat || dres[2].sat;
            end else begin
                m_data_reg <= {{(3*mjq_pkg::DATA_W){1'b0}},
                               tail.coef2, tail.coef1, tail.coef0};
                m_sat_reg  <= 1'b0;
            end
        end
    end

endmodule

### sv/min_jerk_quintic_coefficients_top.sv
// min_jerk_quintic_coefficients_top: one-axis minimum-jerk quintic solver
// depends on mjq_pkg, mjq_front, mjq_fifo, mjq_back
//
// Input words carry the start and goal position, velocity and acceleration
// (signed Q16.16) and the duration (unsigned Q8.16). Each word gives one
// result word with the six coefficients on m_tdata and the clamp flag on
// m_tuser. The front pipeline (5 stages) forms the numerators and the powers
// of the duration, a 4-entry queue decouples it from the back, where three
// 32-stage dividers (one quotient bit per stage) run in parallel.
// When nothing stalls, one word is accepted and one delivered every cycle.
// A stall on m_tready freezes the back; the front keeps taking words until
// the queue fills, then s_tready drops. Results leave in input order.
// Reset (aresetn low, synchronous) empties every stage and the queue.

module min_jerk_quintic_coefficients_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // start_pos, start_vel, start_acc, goal_pos, goal_vel, goal_acc, duration
    input  logic [mjq_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // coef0, coef1, coef2, coef3, coef4, coef5
    output logic [mjq_pkg::OUT_W-1:0] m_tdata,
    // saturated
    output logic                      m_tuser
);

    mjq_pkg::job_t front_job, queue_job;
    logic push, pop, full, empty;

    mjq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_full (full),
        .push      (push),
        .job       (front_job)
    );

    mjq_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (front_job),
        .full    (full),
        .pop     (pop),
        .dout    (queue_job),
        .empty   (empty)
    );

    mjq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job        (queue_job),
        .fifo_empty (empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### sv/mjq_checker.sv
// mjq_checker: port-level checks on the result channel of the solver
// bound to min_jerk_quintic_coefficients_top; uses mjq_pkg

module mjq_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [mjq_pkg::OUT_W-1:0] m_tdata,
    input logic                      m_tuser
);

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_word_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a clamp flag needs at least one high coefficient at a range limit
    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata[127:96]  == mjq_pkg::POS_LIMIT) ||
            (m_tdata[127:96]  == mjq_pkg::NEG_LIMIT) ||
            (m_tdata[159:128] == mjq_pkg::POS_LIMIT) ||
            (m_tdata[159:128] == mjq_pkg::NEG_LIMIT) ||
            (m_tdata[191:160] == mjq_pkg::POS_LIMIT) ||
            (m_tdata[191:160] == mjq_pkg::NEG_LIMIT))
        else $error("saturated set with no clamped coefficient");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind min_jerk_quintic_coefficients_top mjq_checker u_mjq_checker (.*);

### test/min_jerk_quintic_coefficients_top_tb.sv
// min_jerk_quintic_coefficients_top_tb: self-checking bench for the quintic coefficient solver
// depends on mjq_pkg and min_jerk_quintic_coefficients_top
// drives both streams and predicts the exact coefficients
`timescale 1ns / 100ps

module min_jerk_quintic_coefficients_top_tb;

    localparam int N_RANDOM    = 1750;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN       = 60;

    typedef struct packed {
        logic [31:0] sp, sv, sa, gp, gv, ga;
        logic [23:0] dur;
    } traj_t;

    typedef struct packed {
        logic [31:0] c0, c1, c2, c3, c4, c5;
        logic        sat;
    } coefs_t;

    typedef struct {
        traj_t  t;
        bit     known;
        coefs_t c;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [mjq_pkg::IN_W-1:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [mjq_pkg::OUT_W-1:0] m_tdata;
    logic         m_tuser;

    coefs_t pending_coefs[$];
    coefs_t typed_coefs[$];
    bit     typed_flag[$];
    bit     failed = 0;
    int     cycles = 0;
    bit     sink_burst = 0;
    int     stall_left = 0;
    row_t   dir_rows[$];

    min_jerk_quintic_coefficients_top dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("min_jerk_quintic_coefficients_top_tb: FAIL");
            $finish;
        end
    end

    // signed numerator over positive denominator, half away from zero, clamped to int32
    function automatic logic [31:0] div_round_clamp(input logic signed [255:0] num,
                                                    input logic [255:0] den, inout bit sat);
        logic [255:0] mag, q, r;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = mag / den;
        r = mag % den;
        if ((r << 1) >= den) q = q + 1;
        if (neg) begin
            if (q > 256'h8000_0000) begin sat = 1; return mjq_pkg::NEG_LIMIT; end
            return -q[31:0];
        end
        if (q > 256'h7FFF_FFFF) begin sat = 1; return mjq_pkg::POS_LIMIT; end
        return q[31:0];
    endfunction

    function automatic coefs_t solve_quintic(input traj_t t);
        coefs_t c;
        logic signed [255:0] p0, v0, s0, p1, v1, s1, d, x0, x1d, x2dd, d3;
        longint a;
        bit sat;
        sat = 0;
        p0 = $signed(t.sp); v0 = $signed(t.sv); s0 = $signed(t.sa);
        p1 = $signed(t.gp); v1 = $signed(t.gv); s1 = $signed(t.ga);
        d = {232'b0, t.dur};
        a = $signed(t.sa);
        a = (a >= 0) ? (a + 1) / 2 : -((1 - a) / 2);
        c.c0 = t.sp; c.c1 = t.sv; c.c2 = a[31:0];
        c.c3 = '0; c.c4 = '0; c.c5 = '0;
        if (t.dur != 0) begin
            x0 = ((p1 - p0) <<< 33) - ((v0 * d) <<< 17) - s0 * d * d;
            x1d = ((v1 - v0) * 65536 - s0 * d) * d;
            x2dd = (s1 - s0) * d * d;
            d3 = d * d * d;
            c.c3 = div_round_clamp((10 * x0 - 8 * x1d + x2dd) <<< 15, d3, sat);
            c.c4 = div_round_clamp((14 * x1d - 15 * x0 - 2 * x2dd) <<< 31, d3 * d, sat);
            c.c5 = div_round_clamp((6 * x0 - 6 * x1d + x2dd) <<< 47, d3 * d * d, sat);
        end
        c.sat = sat;
        return c;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom) >>> $urandom_range(8, 30);
            2: return $signed($urandom) >>> 12;
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom) >>> 20;
        endcase
    endfunction

    function automatic logic [23:0] rand_dur();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(1, 16);
            2: return 24'hFFFF00 | $urandom_range(0, 255);
            3: return 24'd0;
            default: return $urandom_range(24'h4000, 24'h4_0000);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // accepted input words and delivered result words, both at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            traj_t tin;
            tin.sp  = s_tdata[31:0];
            tin.sv  = s_tdata[63:32];
            tin.sa  = s_tdata[95:64];
            tin.gp  = s_tdata[127:96];
            tin.gv  = s_tdata[159:128];
            tin.ga  = s_tdata[191:160];
            tin.dur = s_tdata[215:192];
            pending_coefs.push_back(solve_quintic(tin));
        end
        if (aresetn && m_tvalid && m_tready) begin
            coefs_t got, exp_c;
            got.c0  = m_tdata[31:0];
            got.c1  = m_tdata[63:32];
            got.c2  = m_tdata[95:64];
            got.c3  = m_tdata[127:96];
            got.c4  = m_tdata[159:128];
            got.c5  = m_tdata[191:160];
            got.sat = m_tuser;
            if (pending_coefs.size() == 0) begin
                $display("%0t unexpected word %h", $time, got);
                failed = 1;
            end else begin
                exp_c = pending_coefs.pop_front();
                if (typed_flag.size() != 0) begin
                    if (typed_flag.pop_front()) exp_c = typed_coefs.pop_front();
                end
                if (got.c0 !== exp_c.c0) begin
                    $display("%0t coef0 exp %h got %h", $time, exp_c.c0, got.c0);
                    failed = 1;
                end
                if (got.c1 !== exp_c.c1) begin
                    $display("%0t coef1 exp %h got %h", $time, exp_c.c1, got.c1);
                    failed = 1;
                end
                if (got.c2 !== exp_c.c2) begin
                    $display("%0t coef2 exp %h got %h", $time, exp_c.c2, got.c2);
                    failed = 1;
                end
                if (got.c3 !== exp_c.c3) begin
                    $display("%0t coef3 exp %h got %h", $time, exp_c.c3, got.c3);
                    failed = 1;
                end
                if (got.c4 !== exp_c.c4) begin
                    $display("%0t coef4 exp %h got %h", $time, exp_c.c4, got.c4);
                    failed = 1;
                end
                if (got.c5 !== exp_c.c5) begin
                    $display("%0t coef5 exp %h got %h", $time, exp_c.c5, got.c5);
                    failed = 1;
                end
                if (got.sat !== exp_c.sat) begin
                    $display("%0t saturated exp %b got %b", $time, exp_c.sat, got.sat);
                    failed = 1;
                end
            end
        end
    end

    // receiver stalls, a few long ones, with stretches of no stall
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) sink_burst <= ~sink_burst;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 299) == 0) begin
            stall_left = $urandom_range(10, 40);
            m_tready <= 1'b0;
        end else if (sink_burst) m_tready <= 1'b1;
        else begin
            int r;
            r = $urandom_range(0, 99);
            m_tready <= (r < 70) || (r >= 98 && $urandom_range(0, 1));
        end
    end

    task automatic send_word(input traj_t t, input bit no_gap);
        int g;
        g = no_gap ? 0 : pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t.dur, t.ga, t.gv, t.gp, t.sa, t.sv, t.sp};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic add_row(input traj_t t, input bit known, input coefs_t c);
        row_t r;
        r.t = t; r.known = known; r.c = c;
        dir_rows.push_back(r);
    endtask

    initial begin
        traj_t t;
        bit burst;
        add_row('0, 1, '0);
        // zero duration: only the low coefficients, no solve
        add_row('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 24'd0}, 1,
                '{32'h8000_0000, 32'h8000_0000, 32'hC000_0000, 0, 0, 0, 1'b0});
        add_row('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 24'd0}, 1,
                '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 0, 0, 0, 1'b0});
        add_row('{32'h1, 32'h2, 32'h1, 32'h0, 32'h0, 32'h0, 24'd0}, 1,
                '{32'h1, 32'h2, 32'h1, 0, 0, 0, 1'b0});
        add_row('{32'h5, 32'h6, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 24'd0}, 1,
                '{32'h5, 32'h6, 32'hFFFF_FFFF, 0, 0, 0, 1'b0});
        add_row('{32'h5, 32'h6, 32'hFFFF_FFFD, 32'h0, 32'h0, 32'h0, 24'd0}, 1,
                '{32'h5, 32'h6, 32'hFFFF_FFFE, 0, 0, 0, 1'b0});
        // nonzero duration rows go through the predictor
        add_row('{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0, 24'h1_0000}, 0, '0);
        add_row('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 24'hFF_FFFF}, 0, '0);
        add_row('{32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 24'd1}, 0, '0);
        add_row('{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 24'd1}, 0, '0);
        add_row('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 24'hFF_FFFF}, 0, '0);
        add_row('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 24'hFF_FFFF}, 0, '0);
        add_row('{32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h1_0000, 32'h2_0000, 32'h3_0000,
                  24'h2_0000}, 0, '0);
        add_row('{32'h0, 32'h1_0000, 32'h0, 32'h2_0000, 32'h1_0000, 32'h0, 24'h2_0000}, 0, '0);
        add_row('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1_0000, 24'h1_8000}, 0, '0);
        add_row('{32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 24'h80_0000}, 0, '0);
        add_row('{32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 24'h00_0100}, 0, '0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            typed_flag.push_back(dir_rows[i].known);
            if (dir_rows[i].known) typed_coefs.push_back(dir_rows[i].c);
            send_word(dir_rows[i].t, 0);
        end

        burst = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
            if (i == N_RANDOM / 2) begin
                s_tvalid <= 1'b0;
                while (pending_coefs.size() != 0) @(negedge aclk);
            end
            t.sp = rand_q16(); t.sv = rand_q16(); t.sa = rand_q16();
            t.gp = rand_q16(); t.gv = rand_q16(); t.ga = rand_q16();
            t.dur = rand_dur();
            send_word(t, burst);
        end
        s_tvalid <= 1'b0;

        while (pending_coefs.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (!failed) begin
            $display("min_jerk_quintic_coefficients_top_tb: PASS");
        end else begin
            $display("min_jerk_quintic_coefficients_top_tb: FAIL");
        end
        $finish;
    end

endmodule
